@@ src/pfdt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pfdt_pkg
// Shared types and codes of the page framebuffer with dirty-region tracking.
// ----------------------------------------------------------------------------
package pfdt_pkg;

	// Command codes of the request channel.
	localparam logic [1:0] CMD_SET_PIXEL = 2'd0;
	localparam logic [1:0] CMD_FILL      = 2'd1;
	localparam logic [1:0] CMD_FLUSH     = 2'd2;
	localparam logic [1:0] CMD_READ_BYTE = 2'd3;

	// Configuration register indexes.
	localparam logic [3:0] CFG_FRAME_WIDTH  = 4'd0;
	localparam logic [3:0] CFG_FRAME_HEIGHT = 4'd1;

	// Marker for a page that has no dirty column.
	localparam logic [7:0] NO_COL = 8'hFF;

	// One request transaction.
	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] col;
		logic [7:0] row;
		logic [2:0] page_sel;
		logic       pixel_on;
	} req_t;

	// One response transaction.
	typedef struct packed {
		logic       region_valid;
		logic [2:0] region_page;
		logic [6:0] region_first_col;
		logic [6:0] region_last_col;
		logic [7:0] byte_data;
		logic       last;
	} rsp_t;

	// Update request from the sequencer to the dirty tracker.
	typedef struct packed {
		logic       set_px;
		logic       fill;
		logic       clear;
		logic [2:0] page;
		logic [7:0] col;
		logic [7:0] width;
	} dirty_op_t;

	// Dirty column span of one page.
	typedef struct packed {
		logic [7:0] first;
		logic [7:0] last;
	} span_t;

endpackage
`default_nettype wire

@@ src/pfdt_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pfdt_store
// Framebuffer byte memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pfdt_store #(
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [7:0]               wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [7:0]               rdata
);

	logic [7:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ src/pfdt_dirty.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pfdt_dirty
// Per-page dirty marks and column spans, with the mask of reportable pages.
// ----------------------------------------------------------------------------
module pfdt_dirty #(
	parameter int MAX_PAGES = 8,
	parameter int PAGE_W    = 3
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire pfdt_pkg::dirty_op_t   op,
	input  wire logic [3:0]            num_pages,
	input  wire logic [PAGE_W-1:0]     sel,
	output logic                       any_dirty,
	output logic      [MAX_PAGES-1:0]  rep_mask,
	output pfdt_pkg::span_t            sel_span
);

	logic [MAX_PAGES-1:0] mark_q;
	logic [7:0]           first_q [MAX_PAGES];
	logic [7:0]           last_q  [MAX_PAGES];
	logic                 any_q;
	logic [PAGE_W-1:0]    op_page;

	assign op_page   = op.page[PAGE_W-1:0];
	assign any_dirty = any_q;

	// Mark and span registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= '0;
			any_q  <= 1'b0;
			for (int p = 0; p < MAX_PAGES; p++) begin
				first_q[p] <= pfdt_pkg::NO_COL;
				last_q[p]  <= 8'd0;
			end
		end else if (op.clear) begin
			mark_q <= '0;
			any_q  <= 1'b0;
			for (int p = 0; p < MAX_PAGES; p++) begin
				first_q[p] <= pfdt_pkg::NO_COL;
				last_q[p]  <= 8'd0;
			end
		end else if (op.fill) begin
			any_q <= 1'b1;
			for (int p = 0; p < MAX_PAGES; p++) begin
				if (4'(p) < num_pages) begin
					mark_q[p]  <= 1'b1;
					first_q[p] <= 8'd0;
					last_q[p]  <= op.width - 8'd1;
				end
			end
		end else if (op.set_px) begin
			any_q           <= 1'b1;
			mark_q[op_page] <= 1'b1;
			if (first_q[op_page] == pfdt_pkg::NO_COL || op.col < first_q[op_page]) begin
				first_q[op_page] <= op.col;
			end
			if (op.col > last_q[op_page]) begin
				last_q[op_page] <= op.col;
			end
		end
	end

	// A page is reported when it is in use, marked and has a proper span.
	always_comb begin
		for (int p = 0; p < MAX_PAGES; p++) begin
			rep_mask[p] = any_q && (4'(p) < num_pages) && mark_q[p]
				&& (first_q[p] != pfdt_pkg::NO_COL) && (last_q[p] >= first_q[p]);
		end
	end

	// Span of the page under the flush walk.
	assign sel_span.first = first_q[sel];
	assign sel_span.last  = last_q[sel];

endmodule
`default_nettype wire

@@ src/page_framebuffer_dirty_tracker.sv @@
`default_nettype none
// Set pixel: the store read is issued at acceptance, then the write-back in SETWR; an out-of-range pixel is dropped.
// Read byte: the store data is registered, then loaded into the output register once the output is free.
// Fill: one store write per cycle over every store byte, with requests stalled until the sweep ends.
// Flush: one page of the walk per cycle, a marked page waiting until the output is free for its region result.
// Reset: marks clear at once; the store is then cleared, with no request accepted until the sweep ends.
// ----------------------------------------------------------------------------
// page_framebuffer_dirty_tracker
// Monochrome page framebuffer with per-page dirty column tracking.
// ----------------------------------------------------------------------------
module page_framebuffer_dirty_tracker #(
	parameter int MAX_COLS  = 128,
	parameter int MAX_PAGES = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire pfdt_pkg::req_t  req,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output pfdt_pkg::rsp_t       rsp,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [3:0]      cfg_index,
	input  wire logic [7:0]      cfg_data
);

	localparam int DEPTH  = MAX_PAGES * MAX_COLS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int PAGE_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SETWR = 3'd2;
	localparam logic [2:0] ST_RDOUT = 3'd3;
	localparam logic [2:0] ST_FLUSH = 3'd4;

	logic [2:0]           state_q;
	logic [ADDR_W-1:0]    sweep_q;
	logic [7:0]           fill_byte_q;
	logic [7:0]           width_q;
	logic [6:0]           height_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [2:0]           bit_q;
	logic                 on_q;
	logic                 rd_ok_q;
	logic [MAX_PAGES-1:0] mask_q;
	logic [PAGE_W-1:0]    pg_q;
	logic                 rsp_valid_q;
	pfdt_pkg::rsp_t       rsp_q;

	logic [7:0]           used_cols;
	logic [3:0]           height_pages;
	logic [3:0]           used_pages;
	logic                 req_acc;
	logic                 set_ok;
	logic                 rd_ok;
	logic                 out_free;
	logic                 mem_we;
	logic [ADDR_W-1:0]    mem_waddr;
	logic [7:0]           mem_wdata;
	logic                 mem_re;
	logic [ADDR_W-1:0]    mem_raddr;
	logic [7:0]           mem_rdata;
	logic [7:0]           bit_mask;
	logic [MAX_PAGES-1:0] rest_mask;
	logic                 flush_emit;
	logic                 flush_empty;
	logic                 rd_emit;
	logic                 any_dirty;
	logic [MAX_PAGES-1:0] rep_mask;
	pfdt_pkg::span_t      span;
	pfdt_pkg::dirty_op_t  dop;

	// Byte address of a page and column.
	function automatic logic [ADDR_W-1:0] addr_of(input logic [2:0] pg, input logic [7:0] c);
		logic [ADDR_W-1:0] base;
		base = ADDR_W'(ADDR_W'(pg) * ADDR_W'(MAX_COLS));
		return base + ADDR_W'(c);
	endfunction

	// Area in use, saturated to the store size.
	assign used_cols    = (width_q > 8'(MAX_COLS)) ? 8'(MAX_COLS) : width_q;
	assign height_pages = height_q[6:3];
	assign used_pages   = (height_pages > 4'(MAX_PAGES)) ? 4'(MAX_PAGES) : height_pages;

	// Request handshake and range checks.
	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign set_ok    = (req.col < used_cols) && ({1'b0, used_pages} > req.row[7:3]);
	assign rd_ok     = (req.col < used_cols) && ({1'b0, req.page_sel} < used_pages);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign cfg_ready = 1'b1;

	// Store read is issued in the cycle the transaction is accepted.
	assign mem_re    = req_acc && (req.cmd == pfdt_pkg::CMD_SET_PIXEL
		|| req.cmd == pfdt_pkg::CMD_READ_BYTE);
	assign mem_raddr = (req.cmd == pfdt_pkg::CMD_READ_BYTE) ? addr_of(req.page_sel, req.col)
		: addr_of(req.row[5:3], req.col);

	// Store write: clearing sweep, or the write-back of a pixel update.
	assign bit_mask  = 8'h01 << bit_q;
	assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_SETWR);
	assign mem_waddr = (state_q == ST_CLEAR) ? sweep_q : addr_q;
	assign mem_wdata = (state_q == ST_CLEAR) ? fill_byte_q
		: (on_q ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask));

	// Flush walk and result emission.
	assign rest_mask   = mask_q & ~(MAX_PAGES'(1) << pg_q);
	assign flush_empty = (state_q == ST_FLUSH) && (mask_q == '0) && out_free;
	assign flush_emit  = (state_q == ST_FLUSH) && mask_q[pg_q] && out_free;
	assign rd_emit     = (state_q == ST_RDOUT) && out_free;

	// Dirty tracker updates.
	assign dop.set_px = req_acc && (req.cmd == pfdt_pkg::CMD_SET_PIXEL) && set_ok;
	assign dop.fill   = req_acc && (req.cmd == pfdt_pkg::CMD_FILL) && (used_cols != 8'd0);
	assign dop.clear  = flush_empty || (flush_emit && (rest_mask == '0));
	assign dop.page   = req.row[5:3];
	assign dop.col    = req.col;
	assign dop.width  = used_cols;

	pfdt_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	pfdt_dirty #(
		.MAX_PAGES(MAX_PAGES),
		.PAGE_W   (PAGE_W)
	) u_dirty (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (dop),
		.num_pages(used_pages),
		.sel      (pg_q),
		.any_dirty(any_dirty),
		.rep_mask (rep_mask),
		.sel_span (span)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 8'd128;
			height_q <= 7'd64;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == pfdt_pkg::CFG_FRAME_WIDTH) begin
				width_q <= cfg_data;
			end else if (cfg_index == pfdt_pkg::CFG_FRAME_HEIGHT) begin
				height_q <= cfg_data[6:0];
			end
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			sweep_q     <= '0;
			fill_byte_q <= 8'd0;
			mask_q      <= '0;
			pg_q        <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sweep_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + ADDR_W'(1);
					end
				end
				ST_IDLE: begin
					if (req_acc) begin
						case (req.cmd)
							pfdt_pkg::CMD_SET_PIXEL: begin
								if (set_ok) begin
									state_q <= ST_SETWR;
								end
							end
							pfdt_pkg::CMD_FILL: begin
								fill_byte_q <= {8{req.pixel_on}};
								sweep_q     <= '0;
								state_q     <= ST_CLEAR;
							end
							pfdt_pkg::CMD_FLUSH: begin
								mask_q  <= rep_mask;
								pg_q    <= '0;
								state_q <= ST_FLUSH;
							end
							default: begin
								state_q <= ST_RDOUT;
							end
						endcase
					end
				end
				ST_SETWR: begin
					state_q <= ST_IDLE;
				end
				ST_RDOUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (flush_empty) begin
						state_q <= ST_IDLE;
					end else if (mask_q[pg_q]) begin
						if (out_free) begin
							mask_q[pg_q] <= 1'b0;
							if (rest_mask == '0) begin
								state_q <= ST_IDLE;
							end else begin
								pg_q <= pg_q + PAGE_W'(1);
							end
						end
					end else begin
						pg_q <= pg_q + PAGE_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Per-transaction fields held across the store access.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			addr_q  <= addr_of(req.row[5:3], req.col);
			bit_q   <= req.row[2:0];
			on_q    <= req.pixel_on;
			rd_ok_q <= rd_ok;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (flush_emit || flush_empty || rd_emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (flush_emit) begin
			rsp_q.region_valid     <= 1'b1;
			rsp_q.region_page      <= 3'(pg_q);
			rsp_q.region_first_col <= span.first[6:0];
			rsp_q.region_last_col  <= span.last[6:0];
			rsp_q.byte_data        <= 8'd0;
			rsp_q.last             <= (rest_mask == '0);
		end else if (flush_empty || rd_emit) begin
			rsp_q.region_valid     <= 1'b0;
			rsp_q.region_page      <= 3'd0;
			rsp_q.region_first_col <= 7'd0;
			rsp_q.region_last_col  <= 7'd0;
			rsp_q.byte_data        <= (rd_emit && rd_ok_q) ? mem_rdata : 8'd0;
			rsp_q.last             <= 1'b1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A reported region never has its first column past its last.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.region_valid |-> rsp.region_first_col <= rsp.region_last_col)
		else $error("region span reversed");

	// Results that describe no region always close their transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.region_valid |-> rsp.last)
		else $error("non-region result without last");

	// No page is reportable while the tracker holds nothing dirty.
	assert property (@(posedge clk) disable iff (!arst_n)
		!any_dirty |-> rep_mask == '0)
		else $error("reportable page with no dirty state");

	// The store is never written by a pixel update during a flush walk.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH |-> !mem_we)
		else $error("store write during flush");

endmodule
`default_nettype wire
